// ===== src/kmc_pkg.sv =====
// Shared constants, types and helpers of the two-choice hash k-mer counter.
package kmc_pkg;

    localparam int TABLE_ENTRIES = 131072;
    localparam int TABLE_AW = $clog2(TABLE_ENTRIES);
    localparam int KEY_W = 64;
    localparam int CNT_W = 32;
    localparam int SEG_W = 19;
    localparam int SHIFT_W = 6;
    localparam int CFG_IDX_W = 8;
    localparam int SLOT_W = KEY_W + CNT_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int OUT_DATA_W = 88;

    localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int MIX_SHIFT = 33;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SEG_W-1:0] SEG_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTE_SHIFT = 8'd1;

    localparam logic [KEY_W-1:0] MARKER_RESET = '1;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd6;

    typedef enum logic [2:0] {
        STAT_HIT_ONE = 3'd0,
        STAT_HIT_TWO = 3'd1,
        STAT_INS_ONE = 3'd2,
        STAT_INS_TWO = 3'd3,
        STAT_DROPPED = 3'd4,
        STAT_SEG_END = 3'd5
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]   empty_marker;
        logic [SHIFT_W-1:0] route_shift;
    } cfg_t;

    typedef struct packed {
        logic                seg_end;
        logic [KEY_W-1:0]    key;
        logic [TABLE_AW-1:0] idx_one;
        logic [TABLE_AW-1:0] idx_two;
    } work_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

// ===== src/two_choice_hash_kmer_counter_unit.sv =====
// Two-choice hash k-mer counter: configuration registers and block top level.
// An item passes the front pipeline, the queue, the table lookup and the result register.
// The read-then-write pass over the table RAMs sets the rate: the back end takes no new item while one is in lookup.
// A segment end additionally holds the input while both tables clear.
// Reset: a clearing pass over all TABLE_ENTRIES slots writes all-ones keys and zero counts;
// s_tready stays low until it ends, while configuration writes are taken throughout.
module two_choice_hash_kmer_counter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // kmer
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // key_count, segment_unique, total_unique
    output logic [2:0]  m_tuser    // status
);
    import kmc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    back_stat_t back_stat;
    work_t      q_in;
    work_t      q_head;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_EMPTY_MARKER: cfg_next.empty_marker = cfg_data;
                REG_ROUTE_SHIFT:  cfg_next.route_shift = cfg_data[SHIFT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.empty_marker <= MARKER_RESET;
            cfg_reg.route_shift <= SHIFT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    kmc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .back_stat (back_stat),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    kmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    kmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .back_stat (back_stat),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== src/kmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/kmc_front.sv =====
// Front end: accepts items, forms table one's index from the shifted key and table two's through the pipelined mixer.
module kmc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kmc_pkg::cfg_t         cfg,
    input  kmc_pkg::back_stat_t   back_stat,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // kmer
    input  logic                  s_tuser,   // operation
    input  logic                  q_full,
    output logic                  q_push,
    output kmc_pkg::work_t        q_data
);
    import kmc_pkg::*;

    logic adv;
    logic accept;
    logic [4:0] v_reg;
    logic [4:0] v_next;

    logic [KEY_W-1:0]    key_reg [5];
    logic                op_reg [5];
    logic [TABLE_AW-1:0] idx_one_reg [5];

    logic [KEY_W-1:0] mix0_reg;
    logic [KEY_W-1:0] mix2_reg;
    logic [63:0]      lo1_reg;
    logic [31:0]      crossa1_reg;
    logic [31:0]      crossb1_reg;
    logic [63:0]      lo3_reg;
    logic [31:0]      crossa3_reg;
    logic [31:0]      crossb3_reg;
    logic [TABLE_AW-1:0] idx_two_reg;

    logic [KEY_W-1:0] shifted;
    logic [KEY_W-1:0] mix0_next;
    logic [63:0]      lo1_next;
    logic [31:0]      crossa1_next;
    logic [31:0]      crossb1_next;
    logic [KEY_W-1:0] prod1;
    logic [KEY_W-1:0] mix2_next;
    logic [63:0]      lo3_next;
    logic [31:0]      crossa3_next;
    logic [31:0]      crossb3_next;
    logic [KEY_W-1:0] prod3;
    logic [KEY_W-1:0] hash;

    assign adv = !v_reg[4] || !q_full;
    assign s_tready = adv && !back_stat.clearing;
    assign accept = s_tvalid && s_tready;
    assign q_push = v_reg[4] && !q_full;

    assign shifted = s_tdata >> cfg.route_shift;
    assign mix0_next = s_tdata ^ (s_tdata >> MIX_SHIFT);

    assign lo1_next = 64'(mix0_reg[31:0]) * 64'(MIX_C1[31:0]);
    assign crossa1_next = mix0_reg[63:32] * MIX_C1[31:0];
    assign crossb1_next = mix0_reg[31:0] * MIX_C1[63:32];
    assign prod1 = lo1_reg + {crossa1_reg + crossb1_reg, 32'b0};
    assign mix2_next = prod1 ^ (prod1 >> MIX_SHIFT);

    assign lo3_next = 64'(mix2_reg[31:0]) * 64'(MIX_C2[31:0]);
    assign crossa3_next = mix2_reg[63:32] * MIX_C2[31:0];
    assign crossb3_next = mix2_reg[31:0] * MIX_C2[63:32];
    assign prod3 = lo3_reg + {crossa3_reg + crossb3_reg, 32'b0};
    assign hash = prod3 ^ (prod3 >> MIX_SHIFT);

    always_comb
    begin
        v_next = v_reg;
        if (adv)
        begin
            v_next = {v_reg[3:0], accept};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg[0] <= s_tdata;
            op_reg[0] <= s_tuser;
            idx_one_reg[0] <= shifted[TABLE_AW-1:0];
            mix0_reg <= mix0_next;
            for (int i = 1; i < 5; i++)
            begin
                key_reg[i] <= key_reg[i-1];
                op_reg[i] <= op_reg[i-1];
                idx_one_reg[i] <= idx_one_reg[i-1];
            end
            lo1_reg <= lo1_next;
            crossa1_reg <= crossa1_next;
            crossb1_reg <= crossb1_next;
            mix2_reg <= mix2_next;
            lo3_reg <= lo3_next;
            crossa3_reg <= crossa3_next;
            crossb3_reg <= crossb3_next;
            idx_two_reg <= hash[TABLE_AW-1:0];
        end
    end

    assign q_data.seg_end = op_reg[4];
    assign q_data.key = key_reg[4];
    assign q_data.idx_one = idx_one_reg[4];
    assign q_data.idx_two = idx_two_reg;

endmodule

// ===== src/kmc_queue.sv =====
// Short queue of classified work items between the front and back ends.
module kmc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kmc_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output kmc_pkg::work_t head,
    output logic           empty
);
    import kmc_pkg::*;

    work_t entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   fill_reg;
    logic [QUEUE_AW:0]   fill_next;

    assign full = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/kmc_back.sv =====
// Back end: table lookup and update, segment bookkeeping, clearing pass and result register.
module kmc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  kmc_pkg::cfg_t       cfg,
    output kmc_pkg::back_stat_t back_stat,
    input  logic                q_empty,
    input  kmc_pkg::work_t      q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [87:0]         m_tdata,   // key_count, segment_unique, total_unique
    output logic [2:0]          m_tuser    // status
);
    import kmc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [TABLE_AW-1:0] clr_cnt_reg;
    logic [TABLE_AW-1:0] clr_cnt_next;
    logic [KEY_W-1:0]    clr_val_reg;
    logic [KEY_W-1:0]    clr_val_next;
    logic [SEG_W-1:0]    seg_reg;
    logic [SEG_W-1:0]    seg_next;
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    total_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    work_t               item_reg;
    status_t             out_status_reg;
    status_t             out_status_next;
    logic [CNT_W-1:0]    out_count_reg;
    logic [CNT_W-1:0]    out_count_next;
    logic [SEG_W-1:0]    out_seg_reg;
    logic [SEG_W-1:0]    out_seg_next;
    logic [CNT_W-1:0]    out_total_reg;
    logic [CNT_W-1:0]    out_total_next;
    logic                load_out;

    logic                we_one;
    logic                we_two;
    logic [TABLE_AW-1:0] waddr_one;
    logic [TABLE_AW-1:0] waddr_two;
    logic [SLOT_W-1:0]   wdata_one;
    logic [SLOT_W-1:0]   wdata_two;
    logic [SLOT_W-1:0]   rdata_one;
    logic [SLOT_W-1:0]   rdata_two;

    logic                go;
    logic                hit_one;
    logic                hit_two;
    logic                free_one;
    logic                free_two;
    logic [CNT_W-1:0]    cnt_one;
    logic [CNT_W-1:0]    cnt_two;
    logic [CNT_W:0]      total_sum;

    kmc_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_table_one (
        .clk   (clk),
        .we    (we_one),
        .waddr (waddr_one),
        .wdata (wdata_one),
        .raddr (q_head.idx_one),
        .rdata (rdata_one)
    );

    kmc_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_table_two (
        .clk   (clk),
        .we    (we_two),
        .waddr (waddr_two),
        .wdata (wdata_two),
        .raddr (q_head.idx_two),
        .rdata (rdata_two)
    );

    assign back_stat.clearing = (state_reg == ST_CLEAR);
    assign go = (state_reg == ST_IDLE) && !q_empty && (!out_valid_reg || m_tready);
    assign q_pop = go;

    assign cnt_one = rdata_one[SLOT_W-1:KEY_W];
    assign cnt_two = rdata_two[SLOT_W-1:KEY_W];
    assign hit_one = (rdata_one[KEY_W-1:0] == item_reg.key);
    assign hit_two = (rdata_two[KEY_W-1:0] == item_reg.key);
    assign free_one = (rdata_one[KEY_W-1:0] == cfg.empty_marker);
    assign free_two = (rdata_two[KEY_W-1:0] == cfg.empty_marker);
    assign total_sum = {1'b0, total_reg} + (CNT_W+1)'(seg_reg);

    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_val_next = clr_val_reg;
        seg_next = seg_reg;
        total_next = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        load_out = 1'b0;
        out_status_next = out_status_reg;
        out_count_next = out_count_reg;
        out_seg_next = out_seg_reg;
        out_total_next = out_total_reg;
        we_one = 1'b0;
        we_two = 1'b0;
        waddr_one = item_reg.idx_one;
        waddr_two = item_reg.idx_two;
        wdata_one = {bump(cnt_one), item_reg.key};
        wdata_two = {bump(cnt_two), item_reg.key};

        case (state_reg)
            ST_CLEAR:
            begin
                we_one = 1'b1;
                we_two = 1'b1;
                waddr_one = clr_cnt_reg;
                waddr_two = clr_cnt_reg;
                wdata_one = {{CNT_W{1'b0}}, clr_val_reg};
                wdata_two = {{CNT_W{1'b0}}, clr_val_reg};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == TABLE_AW'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (go)
                begin
                    if (q_head.seg_end)
                    begin
                        total_next = total_sum[CNT_W] ? CNT_MAX : total_sum[CNT_W-1:0];
                        seg_next = '0;
                        clr_val_next = cfg.empty_marker;
                        clr_cnt_next = '0;
                        load_out = 1'b1;
                        out_valid_next = 1'b1;
                        out_status_next = STAT_SEG_END;
                        out_count_next = '0;
                        out_seg_next = seg_reg;
                        out_total_next = total_next;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                load_out = 1'b1;
                out_valid_next = 1'b1;
                out_total_next = total_reg;
                if (hit_one)
                begin
                    we_one = 1'b1;
                    out_status_next = STAT_HIT_ONE;
                    out_count_next = bump(cnt_one);
                end
                else if (hit_two)
                begin
                    we_two = 1'b1;
                    out_status_next = STAT_HIT_TWO;
                    out_count_next = bump(cnt_two);
                end
                else if (free_one)
                begin
                    we_one = 1'b1;
                    wdata_one = {CNT_W'(1), item_reg.key};
                    out_status_next = STAT_INS_ONE;
                    out_count_next = CNT_W'(1);
                end
                else if (free_two)
                begin
                    we_two = 1'b1;
                    wdata_two = {CNT_W'(1), item_reg.key};
                    out_status_next = STAT_INS_TWO;
                    out_count_next = CNT_W'(1);
                end
                else
                begin
                    out_status_next = STAT_DROPPED;
                    out_count_next = '0;
                end
                if (!hit_one && !hit_two && (free_one || free_two) && (seg_reg != SEG_MAX))
                begin
                    seg_next = seg_reg + 1'b1;
                end
                out_seg_next = seg_next;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_cnt_reg <= '0;
            clr_val_reg <= MARKER_RESET;
            seg_reg <= '0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_val_reg <= clr_val_next;
            seg_reg <= seg_next;
            total_reg <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            item_reg <= q_head;
        end
        if (load_out)
        begin
            out_status_reg <= out_status_next;
            out_count_reg <= out_count_next;
            out_seg_reg <= out_seg_next;
            out_total_reg <= out_total_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_status_reg;
    assign m_tdata = {5'b0, out_total_reg, out_seg_reg, out_count_reg};

endmodule
